[design/knap_pkg.sv]
// Shared field widths and controller/datapath interface types for the knapsack solver
package knap_pkg;

    // fixed field widths of the ports
    localparam int unsigned WEIGHT_BITS   = 10;
    localparam int unsigned VALUE_IN_BITS = 16;
    localparam int unsigned CAP_BITS      = 10;
    localparam int unsigned RESULT_BITS   = 32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_item;   // latch the accepted item and start the walk address
        logic walk_issue;  // read one walk entry pair and step down
        logic ans_issue;   // read the entry at the capacity
        logic ans_load;    // capture the answer and rewind for the clear sweep
        logic clr_step;    // zero one table entry and step up
    } knap_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic walk_fits;   // incoming item is not heavier than the capacity
        logic walk_last;   // walk address has reached the item weight
        logic last_item;   // latched last flag of the current item
        logic clr_last;    // clear sweep is at the top entry
    } knap_status_t;

endpackage

[design/knap_ram.sv]
// Generic RAM with one write port and two registered read ports
module knap_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ra_addr,
    output logic [WIDTH-1:0]                        ra_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rb_addr,
    output logic [WIDTH-1:0]                        rb_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read ports
    always_ff @(posedge clk)
    begin
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

[design/knap_ctrl.sv]
// Sequencer for item walk, answer read and table clear sweep
module knap_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  knap_pkg::knap_status_t  status,
    output knap_pkg::knap_cmd_t     cmd,
    output logic                    busy,
    output logic                    done
);

    import knap_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_WALK   = 6'b000010,
        ST_FLUSH  = 6'b000100,
        ST_ANSWER = 6'b001000,
        ST_LOAD   = 6'b010000,
        ST_CLEAR  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // state register, reset starts with a clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = status.walk_fits ? ST_WALK : ST_FLUSH;
                end
            end
            ST_WALK:
            begin
                cmd.walk_issue = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // last update lands in the table here
                state_next = status.last_item ? ST_ANSWER : ST_IDLE;
            end
            ST_ANSWER:
            begin
                cmd.ans_issue = 1'b1;
                state_next    = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.ans_load = 1'b1;
                done_next    = 1'b1;
                state_next   = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

[design/knap_datapath.sv]
// Table RAM, walk addressing and saturating update for the knapsack solver
module knap_datapath #(
    parameter int unsigned TABLE_DEPTH = 1024,
    parameter int unsigned VALUE_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  knap_pkg::knap_cmd_t                   cmd,
    output knap_pkg::knap_status_t                status,
    input  logic                                  cfg_we,
    input  logic [knap_pkg::CAP_BITS-1:0]         cfg_data,
    input  logic [knap_pkg::WEIGHT_BITS-1:0]      item_weight,
    input  logic [knap_pkg::VALUE_IN_BITS-1:0]    item_value,
    input  logic                                  last_item,
    output logic [knap_pkg::RESULT_BITS-1:0]      best_value
);

    import knap_pkg::*;

    localparam int unsigned AW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CMP_BITS = ((AW > CAP_BITS) ? AW : CAP_BITS) + 1;
    localparam int unsigned VB       = (VALUE_BITS < VALUE_IN_BITS) ? VALUE_BITS : VALUE_IN_BITS;
    localparam logic [CMP_BITS-1:0] MAX_IDX = CMP_BITS'(TABLE_DEPTH - 1);

    logic [CAP_BITS-1:0]    capacity_reg;
    logic [AW-1:0]          cap_eff;
    logic [AW-1:0]          cap_reg;
    logic [AW-1:0]          weight_reg;
    logic [VB-1:0]          value_reg;
    logic                   last_reg;
    logic [AW-1:0]          addr_reg;
    logic                   s1_valid_reg;
    logic [AW-1:0]          s1_addr_reg;
    logic [RESULT_BITS-1:0] result_reg;

    logic [AW-1:0]          ra_addr;
    logic [AW-1:0]          rb_addr;
    logic [RESULT_BITS-1:0] ra_data;
    logic [RESULT_BITS-1:0] rb_data;
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [RESULT_BITS-1:0] wdata;
    logic [RESULT_BITS:0]   sum;
    logic [RESULT_BITS-1:0] cand;
    logic                   greater;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '0;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_data;
        end
    end

    // capacity limited to the last table entry
    assign cap_eff = (CMP_BITS'(capacity_reg) > MAX_IDX) ? AW'(MAX_IDX) : AW'(capacity_reg);

    // item registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cap_reg    <= cap_eff;
            weight_reg <= AW'(item_weight);
            value_reg  <= item_value[VB-1:0];
            last_reg   <= last_item;
        end
    end

    // shared address counter: walks down per item, sweeps up when clearing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.walk_issue;
            if (cmd.load_item)
            begin
                addr_reg <= cap_eff;
            end
            else if (cmd.walk_issue)
            begin
                addr_reg <= addr_reg - AW'(1);
            end
            else if (cmd.ans_load)
            begin
                addr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                addr_reg <= addr_reg + AW'(1);
            end
        end
    end

    // address of the entry being updated, registered alongside the read data
    always_ff @(posedge clk)
    begin
        s1_addr_reg <= addr_reg;
    end

    // read addresses
    assign ra_addr = cmd.ans_issue ? cap_reg : addr_reg;
    assign rb_addr = addr_reg - weight_reg;

    // saturating candidate and compare against the old entry
    assign sum     = {1'b0, rb_data} + (RESULT_BITS + 1)'(value_reg);
    assign cand    = sum[RESULT_BITS] ? '1 : sum[RESULT_BITS-1:0];
    assign greater = cand > ra_data;

    // write port: clear sweep or walk update
    always_comb
    begin
        if (cmd.clr_step)
        begin
            we    = 1'b1;
            waddr = addr_reg;
            wdata = '0;
        end
        else
        begin
            we    = s1_valid_reg && greater;
            waddr = s1_addr_reg;
            wdata = cand;
        end
    end

    knap_ram #(
        .WIDTH (RESULT_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .ra_addr (ra_addr),
        .ra_data (ra_data),
        .rb_addr (rb_addr),
        .rb_data (rb_data)
    );

    // answer register
    always_ff @(posedge clk)
    begin
        if (cmd.ans_load)
        begin
            result_reg <= ra_data;
        end
    end

    assign best_value = result_reg;

    // status back to the controller
    assign status.walk_fits = CMP_BITS'(item_weight) <= CMP_BITS'(cap_eff);
    assign status.walk_last = (addr_reg == weight_reg);
    assign status.last_item = last_reg;
    assign status.clr_last  = (CMP_BITS'(addr_reg) == MAX_IDX);

endmodule

[design/zero_one_knapsack_dp.sv]
// Top level of the 0/1 knapsack solver: controller, datapath and checks
// An item is taken when start is high and busy is low. It occupies the block for the
// accepting cycle, a walk from the capacity down to item_weight and a flush state,
// or for the accepting cycle and the flush state only if heavier than the
// capacity (capacity is limited to TABLE_DEPTH-1). After the last item of a set,
// best_value is shown with done high for exactly one cycle, after the flush, answer
// read and answer load states, together with the first step of the clear sweep;
// the receiver cannot stall it and must take it then. The table is then cleared in a
// sweep over all TABLE_DEPTH entries, one entry a cycle, during which busy stays
// high; the same sweep runs after reset. Capacity writes are always taken (cfg_ready
// is tied high) and apply from the next accepted item.
module zero_one_knapsack_dp #(
    parameter int unsigned TABLE_DEPTH = 1024,
    parameter int unsigned VALUE_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [knap_pkg::WEIGHT_BITS-1:0]   item_weight,
    input  logic [knap_pkg::VALUE_IN_BITS-1:0] item_value,
    input  logic                               last_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [knap_pkg::CAP_BITS-1:0]      capacity,
    output logic                               done,
    output logic [knap_pkg::RESULT_BITS-1:0]   best_value
);

    import knap_pkg::*;

    knap_cmd_t    cmd;
    knap_status_t status;

    // configuration transfers are never held off
    assign cfg_ready = 1'b1;

    knap_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    knap_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (capacity),
        .item_weight (item_weight),
        .item_value  (item_value),
        .last_item   (last_item),
        .best_value  (best_value)
    );

`ifndef ASSERT_OFF
    // an accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after item transfer");

    // at most one datapath command at a time
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("overlapping datapath commands");

    // answer read is always followed by its capture
    a_ans_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ans_issue |=> cmd.ans_load)
        else $error("answer read not captured");

    // a result appears only while the clear sweep holds the block busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (busy && cmd.clr_step))
        else $error("result strobe outside clear sweep");
`endif

endmodule
